### sv/wrt_pkg.sv
// Package for the weighted route table lookup block.
// Holds the request kind codes, field widths, LFSR seed and LFSR step function.
// No dependencies.
package wrt_pkg;

  localparam int KindW = 2;
  localparam int LinkIdxW = 3;
  localparam int VnetW = 2;
  localparam int DestW = 64;
  localparam int WeightW = 8;
  localparam int CfgW = 4;
  localparam int LfsrW = 16;

  localparam logic [KindW-1:0] KindRouteWrite = 2'd0;
  localparam logic [KindW-1:0] KindWeightWrite = 2'd1;
  localparam logic [KindW-1:0] KindLookup = 2'd2;

  localparam logic [LfsrW-1:0] LfsrSeed = 16'hACE1;

  // Taps x^16 + x^14 + x^13 + x^11 + 1, shifting right.
  function automatic logic [LfsrW-1:0] lfsr_next(input logic [LfsrW-1:0] s);
    logic fb;
    fb = s[0] ^ s[2] ^ s[3] ^ s[5];
    return {fb, s[LfsrW-1:1]};
  endfunction

endpackage

### sv/weighted_route_table_lookup.sv
// A write does not make the block busy; a lookup on an unknown virtual network answers in the
// next cycle. A lookup scans the links twice through the shared read ports, first for the least
// weight and then for the links that carry it, decides, reduces the LFSR modulo the set size
// when the vnet is unordered, then walks the links to the chosen one. Busy is high until the
// result is shown, and the next request is taken while the result is shown. Reset clears both
// tables while busy is high.
module weighted_route_table_lookup
  import wrt_pkg::*;
#(
  parameter int NUM_LINKS = 8,
  parameter int NUM_VNETS = 4,
  parameter int NUM_DESTS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [KindW-1:0]    kind_i,
  input  logic [LinkIdxW-1:0] link_index_i,
  input  logic [VnetW-1:0]    vnet_i,
  input  logic [DestW-1:0]    dest_mask_i,
  input  logic [WeightW-1:0]  weight_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgW-1:0]     cfg_data_i,
  output logic                done_o,
  output logic [LinkIdxW-1:0] link_o,
  output logic                no_route_o
);

  localparam int LkW = NUM_LINKS > 1 ? $clog2(NUM_LINKS) : 1;
  localparam int VnW = NUM_VNETS > 1 ? $clog2(NUM_VNETS) : 1;
  localparam int AW = LkW + VnW;
  localparam int RouteDepth = 2 ** AW;
  localparam int WeightDepth = 2 ** LkW;
  localparam int CntW = $clog2(NUM_LINKS + 1);
  localparam int StepW = $clog2(LfsrW);
  localparam logic [DestW-1:0] DestBits = {DestW{1'b1}} >> (DestW - NUM_DESTS);
  localparam logic [WeightW:0] MinInit = {1'b1, {WeightW{1'b0}}};
  localparam logic [CntW-1:0] LastCnt = CntW'(NUM_LINKS);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StClear = 3'd1;
  localparam logic [2:0] StPass1 = 3'd2;
  localparam logic [2:0] StPass2 = 3'd3;
  localparam logic [2:0] StDecide = 3'd4;
  localparam logic [2:0] StMod = 3'd5;
  localparam logic [2:0] StPick = 3'd6;

  logic [2:0]          state_q, state_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [StepW-1:0]    step_q, step_d;
  logic [LfsrW-1:0]    lfsr_q, lfsr_d;
  logic [CfgW-1:0]     ordered_q, ordered_d;
  logic                done_q, done_d;
  logic [VnW-1:0]      vnet_q, vnet_d;
  logic [DestW-1:0]    dmask_q, dmask_d;
  logic [NUM_LINKS-1:0] cand_q, cand_d;
  logic [NUM_LINKS-1:0] set_q, set_d;
  logic [WeightW:0]    min_q, min_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     pick_q, pick_d;
  logic [CntW:0]       rem_q, rem_d;
  logic [LfsrW-1:0]    div_q, div_d;
  logic [LinkIdxW-1:0] link_q, link_d;
  logic                nor_q, nor_d;

  logic                accept;
  logic                link_ok;
  logic                vnet_ok;
  logic [LkW-1:0]      link_ext;
  logic [VnW-1:0]      vnet_ext;
  logic [LkW-1:0]      prev_idx;
  logic [LkW-1:0]      cur_idx;
  logic                clearing;
  logic                rt_we;
  logic [AW-1:0]       rt_waddr;
  logic [DestW-1:0]    rt_wdata;
  logic [DestW-1:0]    rt_rdata;
  logic                wt_we;
  logic [LkW-1:0]      wt_waddr;
  logic [WeightW-1:0]  wt_wdata;
  logic [WeightW-1:0]  wt_rdata;
  logic                cand;
  logic                w_lt;
  logic                w_eq;
  logic [CntW:0]       rem_sh;
  logic [LfsrW-1:0]    lfsr_adv;

  assign busy = state_q != StIdle;
  assign cfg_ready_o = 1'b1;
  assign accept = start && !busy;
  assign link_ext = LkW'(link_index_i);
  assign vnet_ext = VnW'(vnet_i);
  assign link_ok = 32'(link_index_i) < NUM_LINKS;
  assign vnet_ok = 32'(vnet_i) < NUM_VNETS;
  assign prev_idx = LkW'(cnt_q - CntW'(1));
  assign cur_idx = cnt_q[LkW-1:0];
  assign clearing = state_q == StClear;

  assign rt_we = clearing || (accept && kind_i == KindRouteWrite && link_ok && vnet_ok);
  assign rt_waddr = clearing ? clr_q : {vnet_ext, link_ext};
  assign rt_wdata = clearing ? '0 : (dest_mask_i & DestBits);
  assign wt_we = clearing || (accept && kind_i == KindWeightWrite && link_ok);
  assign wt_waddr = clearing ? clr_q[LkW-1:0] : link_ext;
  assign wt_wdata = clearing ? '0 : weight_i;

  wrt_ram #(
    .Width(DestW),
    .Depth(RouteDepth)
  ) u_route_ram (
    .clk_i  (clk_i),
    .we_i   (rt_we),
    .waddr_i(rt_waddr),
    .wdata_i(rt_wdata),
    .raddr_i({vnet_q, cur_idx}),
    .rdata_o(rt_rdata)
  );

  wrt_ram #(
    .Width(WeightW),
    .Depth(WeightDepth)
  ) u_weight_ram (
    .clk_i  (clk_i),
    .we_i   (wt_we),
    .waddr_i(wt_waddr),
    .wdata_i(wt_wdata),
    .raddr_i(cur_idx),
    .rdata_o(wt_rdata)
  );

  // Both scans share the read ports: a less-than weight compare first, then an equality one.
  assign cand = |(rt_rdata & dmask_q);
  assign w_lt = {1'b0, wt_rdata} < min_q;
  assign w_eq = {1'b0, wt_rdata} == min_q;
  assign rem_sh = {rem_q[CntW-1:0], div_q[LfsrW-1]};
  assign lfsr_adv = lfsr_next(lfsr_q);

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    cnt_d = cnt_q;
    step_d = step_q;
    lfsr_d = lfsr_q;
    ordered_d = cfg_valid_i ? cfg_data_i : ordered_q;
    done_d = 1'b0;
    vnet_d = vnet_q;
    dmask_d = dmask_q;
    cand_d = cand_q;
    set_d = set_q;
    min_d = min_q;
    count_d = count_q;
    pick_d = pick_q;
    rem_d = rem_q;
    div_d = div_q;
    link_d = link_q;
    nor_d = nor_q;
    unique case (state_q)
      StIdle: begin
        if (accept && kind_i == KindLookup) begin
          if (!vnet_ok) begin
            done_d = 1'b1;
            link_d = '0;
            nor_d = 1'b1;
          end else begin
            vnet_d = vnet_ext;
            dmask_d = dest_mask_i & DestBits;
            cnt_d = '0;
            cand_d = '0;
            set_d = '0;
            min_d = MinInit;
            count_d = '0;
            state_d = StPass1;
          end
        end
      end
      StClear: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(RouteDepth - 1)) begin
          state_d = StIdle;
        end
      end
      StPass1: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q != '0 && cand) begin
          cand_d[prev_idx] = 1'b1;
          if (w_lt) begin
            min_d = {1'b0, wt_rdata};
          end
        end
        if (cnt_q == LastCnt) begin
          cnt_d = '0;
          state_d = StPass2;
        end
      end
      StPass2: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q != '0 && cand_q[prev_idx] && w_eq) begin
          set_d[prev_idx] = 1'b1;
          count_d = count_q + CntW'(1);
        end
        if (cnt_q == LastCnt) begin
          cnt_d = '0;
          state_d = StDecide;
        end
      end
      StDecide: begin
        pick_d = '0;
        cnt_d = '0;
        if (count_q == '0) begin
          done_d = 1'b1;
          link_d = '0;
          nor_d = 1'b1;
          state_d = StIdle;
        end else if (ordered_q[vnet_q]) begin
          state_d = StPick;
        end else begin
          lfsr_d = lfsr_adv;
          div_d = lfsr_adv;
          rem_d = '0;
          step_d = '0;
          state_d = StMod;
        end
      end
      StMod: begin
        div_d = {div_q[LfsrW-2:0], 1'b0};
        step_d = step_q + StepW'(1);
        if (rem_sh >= {1'b0, count_q}) begin
          rem_d = rem_sh - {1'b0, count_q};
        end else begin
          rem_d = rem_sh;
        end
        if (step_q == StepW'(LfsrW - 1)) begin
          pick_d = rem_d[CntW-1:0];
          state_d = StPick;
        end
      end
      StPick: begin
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q >= LastCnt) begin
          done_d = 1'b1;
          link_d = '0;
          nor_d = 1'b1;
          state_d = StIdle;
        end else if (set_q[cur_idx]) begin
          if (pick_q == '0) begin
            done_d = 1'b1;
            link_d = LinkIdxW'(cur_idx);
            nor_d = 1'b0;
            state_d = StIdle;
          end else begin
            pick_d = pick_q - CntW'(1);
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
      cnt_q <= '0;
      step_q <= '0;
      lfsr_q <= LfsrSeed;
      ordered_q <= '0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      cnt_q <= cnt_d;
      step_q <= step_d;
      lfsr_q <= lfsr_d;
      ordered_q <= ordered_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vnet_q <= vnet_d;
    dmask_q <= dmask_d;
    cand_q <= cand_d;
    set_q <= set_d;
    min_q <= min_d;
    count_q <= count_d;
    pick_q <= pick_d;
    rem_q <= rem_d;
    div_q <= div_d;
    link_q <= link_d;
    nor_q <= nor_d;
  end

  assign done_o = done_q;
  assign link_o = link_q;
  assign no_route_o = nor_q;

endmodule

### sv/wrt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the route mask and link weight stores. No dependencies.
module wrt_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### sv/wrt_checker.sv
// Port-level checker for the weighted route table lookup block, with its bind statement.
// Depends on wrt_pkg.
module wrt_checker
  import wrt_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic [KindW-1:0]    kind_i,
  input logic                done_o,
  input logic [LinkIdxW-1:0] link_o,
  input logic                no_route_o
);

  // A failed lookup always reports link zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && no_route_o |-> link_o == '0)
    else $error("no-route result with nonzero link");

  // A result follows either a lookup request taken while idle or the end of busy work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy) || ($past(start) && $past(kind_i) == KindLookup))
    else $error("result without a lookup request");

  // Write and reserved-kind requests never make the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && kind_i != KindLookup |=> !busy)
    else $error("write request left the block busy");

  // A write request produces no result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && kind_i != KindLookup |=> !done_o)
    else $error("result after a write request");

endmodule

bind weighted_route_table_lookup wrt_checker u_wrt_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .kind_i    (kind_i),
  .done_o    (done_o),
  .link_o    (link_o),
  .no_route_o(no_route_o)
);

### dv/tb_weighted_route_table_lookup.sv
`timescale 1ns / 100ps
// Self-checking testbench for weighted_route_table_lookup: a directed table, then random
// request bursts over six vnet-order settings, each lookup checked by model or typed row.
// Depends on wrt_pkg and the weighted_route_table_lookup RTL.
module tb_weighted_route_table_lookup;
  import wrt_pkg::*;

  localparam int NumLinks = 8;
  localparam int NumVnets = 4;
  localparam int NumDests = 64;
  localparam logic [KindW-1:0] KindReserved = 2'd3;
  localparam int SettleCycles = 60;

  typedef struct packed {
    logic                set_cfg;
    logic [CfgW-1:0]     cfg_val;
    logic [KindW-1:0]    kind;
    logic [LinkIdxW-1:0] link_idx;
    logic [VnetW-1:0]    vnet;
    logic [DestW-1:0]    mask;
    logic [WeightW-1:0]  weight;
    logic                typed;
    logic [LinkIdxW-1:0] exp_link;
    logic                exp_none;
  } stim_row_t;

  typedef struct packed {
    logic [LinkIdxW-1:0] link;
    logic                no_route;
  } route_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [KindW-1:0]    kind_i = '0;
  logic [LinkIdxW-1:0] link_index_i = '0;
  logic [VnetW-1:0]    vnet_i = '0;
  logic [DestW-1:0]    dest_mask_i = '0;
  logic [WeightW-1:0]  weight_i = '0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgW-1:0]     cfg_data_i = '0;
  logic                done_o;
  logic [LinkIdxW-1:0] link_o;
  logic                no_route_o;

  logic                fixed_valid = 1'b0;
  route_result_t       fixed_result = '0;

  logic [DestW-1:0]    route_tbl [NumVnets][NumLinks];
  logic [WeightW-1:0]  weight_tbl [NumLinks];
  logic [LfsrW-1:0]    rng_state;
  logic [CfgW-1:0]     ordered_cfg;
  route_result_t       pending_routes [$];
  int unsigned         mismatch_count = 0;
  stim_row_t           dir_rows [$];

  weighted_route_table_lookup #(
    .NUM_LINKS(NumLinks),
    .NUM_VNETS(NumVnets),
    .NUM_DESTS(NumDests)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .kind_i(kind_i),
    .link_index_i(link_index_i),
    .vnet_i(vnet_i),
    .dest_mask_i(dest_mask_i),
    .weight_i(weight_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i(cfg_data_i),
    .done_o(done_o),
    .link_o(link_o),
    .no_route_o(no_route_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb_weighted_route_table_lookup: done, errors");
    $finish;
  end

  function automatic route_result_t predict_route(input logic [VnetW-1:0] vn,
                                                  input logic [DestW-1:0] dm);
    route_result_t res;
    int unsigned   min_w;
    int unsigned   cnt;
    int unsigned   sel;
    logic          hit;
    min_w = 256;
    cnt = 0;
    sel = 0;
    res.link = '0;
    res.no_route = 1'b1;
    for (int l = 0; l < NumLinks; l++) begin
      hit = (route_tbl[vn][l] & dm) != '0;
      if (hit && weight_tbl[l] < min_w) min_w = 32'(weight_tbl[l]);
    end
    for (int l = 0; l < NumLinks; l++) begin
      hit = (route_tbl[vn][l] & dm) != '0;
      if (hit && weight_tbl[l] == min_w) cnt++;
    end
    if (cnt != 0) begin
      if (!ordered_cfg[vn]) begin
        rng_state = {rng_state[0] ^ rng_state[2] ^ rng_state[3] ^ rng_state[5],
                     rng_state[LfsrW-1:1]};
        sel = 32'(rng_state) % cnt;
      end
      for (int l = 0; l < NumLinks; l++) begin
        hit = (route_tbl[vn][l] & dm) != '0;
        if (hit && weight_tbl[l] == min_w && res.no_route) begin
          if (sel == 0) begin
            res.link = l[LinkIdxW-1:0];
            res.no_route = 1'b0;
          end else begin
            sel--;
          end
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    route_result_t got;
    route_result_t want;
    if (!rst_ni) begin
      for (int v = 0; v < NumVnets; v++)
        for (int l = 0; l < NumLinks; l++) route_tbl[v][l] = '0;
      for (int l = 0; l < NumLinks; l++) weight_tbl[l] = '0;
      rng_state = LfsrSeed;
      ordered_cfg = '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) ordered_cfg = cfg_data_i;
      if (done_o) begin
        got.link = link_o;
        got.no_route = no_route_o;
        if (pending_routes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: link %0d no_route %0b", got.link, got.no_route);
        end else begin
          want = pending_routes.pop_front();
          if (got != want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected link %0d no_route %0b, got link %0d no_route %0b",
                       want.link, want.no_route, got.link, got.no_route);
          end
        end
      end
      if (start && !busy) begin
        case (kind_i)
          KindRouteWrite: begin
            route_tbl[vnet_i][link_index_i] = dest_mask_i;
          end
          KindWeightWrite: begin
            weight_tbl[link_index_i] = weight_i;
          end
          KindLookup: begin
            want = predict_route(vnet_i, dest_mask_i);
            if (fixed_valid) want = fixed_result;
            pending_routes.insert(pending_routes.size(), want);
          end
          default: begin
          end
        endcase
      end
    end
  end

  function automatic stim_row_t mk_row(input logic set_cfg, input logic [CfgW-1:0] cfg_val,
                                       input logic [KindW-1:0] kind,
                                       input logic [LinkIdxW-1:0] link_idx,
                                       input logic [VnetW-1:0] vnet,
                                       input logic [DestW-1:0] mask,
                                       input logic [WeightW-1:0] weight, input logic typed,
                                       input logic [LinkIdxW-1:0] exp_link,
                                       input logic exp_none);
    stim_row_t r;
    r.set_cfg = set_cfg;
    r.cfg_val = cfg_val;
    r.kind = kind;
    r.link_idx = link_idx;
    r.vnet = vnet;
    r.mask = mask;
    r.weight = weight;
    r.typed = typed;
    r.exp_link = exp_link;
    r.exp_none = exp_none;
    return r;
  endfunction

  function automatic void add_row(input stim_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic logic [DestW-1:0] rand_mask();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, DestW - 1);
      3, 4: return {$urandom, $urandom};
      default: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
    endcase
  endfunction

  function automatic stim_row_t rand_row();
    stim_row_t   r;
    int unsigned pick;
    r = '0;
    pick = $urandom_range(0, 99);
    if (pick < 35) r.kind = KindRouteWrite;
    else if (pick < 47) r.kind = KindWeightWrite;
    else if (pick < 97) r.kind = KindLookup;
    else r.kind = KindReserved;
    r.link_idx = LinkIdxW'($urandom_range(0, NumLinks - 1));
    r.vnet = VnetW'($urandom_range(0, NumVnets - 1));
    r.mask = rand_mask();
    r.weight = WeightW'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255));
    return r;
  endfunction

  task automatic issue_request(input stim_row_t r);
    start <= 1'b1;
    kind_i <= r.kind;
    link_index_i <= r.link_idx;
    vnet_i <= r.vnet;
    dest_mask_i <= r.mask;
    weight_i <= r.weight;
    fixed_valid <= r.typed;
    fixed_result <= {r.exp_link, r.exp_none};
    do @(posedge clk_i); while (busy);
  endtask

  task automatic set_ordered(input logic [CfgW-1:0] val);
    start <= 1'b0;
    while (pending_routes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [CfgW-1:0] phase_cfg [6];
    stim_row_t       r;
    int unsigned     sent;
    int unsigned     burst;
    int unsigned     gap;
    phase_cfg[0] = 4'h0;
    phase_cfg[1] = 4'h5;
    phase_cfg[2] = CfgW'($urandom_range(0, 15));
    phase_cfg[3] = 4'hF;
    phase_cfg[4] = 4'hA;
    phase_cfg[5] = CfgW'($urandom_range(0, 15));

    add_row(mk_row(1, 4'h0, KindLookup, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_row(0, 0, KindLookup, 0, 0, '1, 0, 1, 0, 1));
    add_row(mk_row(0, 0, KindLookup, 7, 3, '0, 8'hFF, 1, 0, 1));
    add_row(mk_row(0, 0, KindReserved, 7, 3, '1, 8'hFF, 0, 0, 0));
    add_row(mk_row(0, 0, KindRouteWrite, 0, 0, 64'h1, 0, 0, 0, 0));
    add_row(mk_row(0, 0, KindRouteWrite, 7, 0, '1, 0, 0, 0, 0));
    add_row(mk_row(0, 0, KindWeightWrite, 0, 0, 0, 8'hFF, 0, 0, 0));
    add_row(mk_row(0, 0, KindLookup, 0, 0, 64'h1, 0, 1, 7, 0));
    add_row(mk_row(0, 0, KindLookup, 0, 0, '0, 0, 1, 0, 1));
    add_row(mk_row(0, 0, KindRouteWrite, 3, 1, 64'h8000_0000_0000_0000, 0, 0, 0, 0));
    add_row(mk_row(0, 0, KindLookup, 0, 1, 64'h8000_0000_0000_0000, 0, 1, 3, 0));
    add_row(mk_row(0, 0, KindLookup, 0, 1, 64'h7FFF_FFFF_FFFF_FFFF, 0, 1, 0, 1));
    add_row(mk_row(0, 0, KindRouteWrite, 5, 1, 64'h8000_0000_0000_0000, 0, 0, 0, 0));
    add_row(mk_row(0, 0, KindWeightWrite, 3, 0, 0, 8'hFF, 0, 0, 0));
    add_row(mk_row(0, 0, KindWeightWrite, 5, 0, 0, 8'hFF, 0, 0, 0));
    add_row(mk_row(0, 0, KindLookup, 0, 1, 64'h8000_0000_0000_0000, 0, 0, 0, 0));
    add_row(mk_row(0, 0, KindLookup, 0, 1, '1, 0, 0, 0, 0));
    add_row(mk_row(1, 4'hF, KindLookup, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_row(0, 0, KindLookup, 0, 1, 64'h8000_0000_0000_0000, 0, 1, 3, 0));
    add_row(mk_row(0, 0, KindWeightWrite, 5, 0, 0, 8'h00, 0, 0, 0));
    add_row(mk_row(0, 0, KindLookup, 0, 1, '1, 0, 1, 5, 0));
    add_row(mk_row(0, 0, KindRouteWrite, 5, 1, '0, 0, 0, 0, 0));
    add_row(mk_row(0, 0, KindLookup, 0, 1, '1, 0, 1, 3, 0));
    add_row(mk_row(0, 0, KindRouteWrite, 0, 2, '1, 0, 0, 0, 0));
    add_row(mk_row(0, 0, KindLookup, 0, 2, 64'h8, 0, 1, 0, 0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_cfg) set_ordered(dir_rows[i].cfg_val);
      else issue_request(dir_rows[i]);
    end

    for (int p = 0; p < 6; p++) begin
      set_ordered(phase_cfg[p]);
      sent = 0;
      while (sent < 292) begin
        burst = $urandom_range(1, 40);
        for (int b = 0; b < burst; b++) begin
          r = rand_row();
          issue_request(r);
          if (r.kind != KindReserved) sent++;
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        if (gap != 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end

    start <= 1'b0;
    while (pending_routes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_routes.size() == 0)
      $display("tb_weighted_route_table_lookup: done, clean");
    else
      $display("tb_weighted_route_table_lookup: done, errors");
    $finish;
  end

endmodule
